@@ rtl/trsh_pkg.sv @@
// ----------------------------------------------------------------------------
// trsh_pkg
// Shared types and constants of the triggered random sample-and-hold.
// ----------------------------------------------------------------------------
package trsh_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SPAN_W  = DATA_W + 1;
    localparam int unsigned PROD_W  = 2 * SPAN_W;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] TRIGGER_LEVEL = 32'h0001_0000;

    localparam logic [DATA_W-1:0] SEED_X = 32'd123456789;
    localparam logic [DATA_W-1:0] SEED_Y = 32'd362436069;
    localparam logic [DATA_W-1:0] SEED_Z = 32'd521288629;
    localparam logic [DATA_W-1:0] SEED_W = 32'd88675123;

    localparam logic [DATA_W-1:0] MIN_RESET = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] MAX_RESET = 32'h0001_0000;

    localparam int unsigned SHIFT_A = 11;
    localparam int unsigned SHIFT_B = 8;
    localparam int unsigned SHIFT_C = 19;

    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN = 1'b0,
        CFG_MAX = 1'b1
    } cfg_idx_t;

    // word passed from the front to the back
    typedef struct packed {
        logic              trig;
        logic [DATA_W-1:0] rnd;
    } trsh_word_t;

    // queue push from the front toward the queue
    typedef struct packed {
        logic       push;
        trsh_word_t word;
    } trsh_push_t;

endpackage

@@ rtl/trsh_front.sv @@
// ----------------------------------------------------------------------------
// trsh_front
// Accepts samples, detects the trigger level and steps the xorshift128
// generator on each trigger.
// ----------------------------------------------------------------------------
module trsh_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [trsh_pkg::DATA_W-1:0]  in_data,
    input  logic                         q_full,
    output logic                         in_ready,
    output trsh_pkg::trsh_push_t         q_push
);
    import trsh_pkg::*;

    logic [DATA_W-1:0] x_reg, y_reg, z_reg, w_reg;
    logic [DATA_W-1:0] t_val, w_next;
    logic              accept;
    logic              trig;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign trig     = (in_data == TRIGGER_LEVEL);

    always_comb
    begin
        t_val  = x_reg ^ (x_reg << SHIFT_A);
        w_next = w_reg ^ (w_reg >> SHIFT_C) ^ t_val ^ (t_val >> SHIFT_B);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= SEED_X;
            y_reg <= SEED_Y;
            z_reg <= SEED_Z;
            w_reg <= SEED_W;
        end
        else if (accept && trig)
        begin
            x_reg <= y_reg;
            y_reg <= z_reg;
            z_reg <= w_reg;
            w_reg <= w_next;
        end
    end

    assign q_push.push      = accept;
    assign q_push.word.trig = trig;
    assign q_push.word.rnd  = w_next;

endmodule

@@ rtl/trsh_queue.sv @@
// ----------------------------------------------------------------------------
// trsh_queue
// Short FIFO between front and back; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module trsh_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  trsh_pkg::trsh_push_t  q_push,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output trsh_pkg::trsh_word_t  head
);
    import trsh_pkg::*;

    trsh_word_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!q_push.push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_push.push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            entry_reg[wr_ptr_reg] <= q_push.word;
    end

endmodule

@@ rtl/trsh_back.sv @@
// ----------------------------------------------------------------------------
// trsh_back
// Scales the random word into [min, max), updates the held value and drives
// the output register.
// ----------------------------------------------------------------------------
module trsh_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [trsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trsh_pkg::DATA_W-1:0]       cfg_data,
    input  logic                              q_not_empty,
    input  trsh_pkg::trsh_word_t              q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    output logic [trsh_pkg::DATA_W-1:0]       out_data,
    input  logic                              out_ready
);
    import trsh_pkg::*;

    logic [DATA_W-1:0]        min_reg, max_reg;
    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] prod;

    logic                     s1_valid_reg;
    logic                     s1_trig_reg;
    logic [DATA_W-1:0]        s1_off_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;
    logic [DATA_W-1:0]        hold_reg, hold_next;

    logic                     out_adv, s1_adv;

    assign out_adv = !out_valid_reg || out_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q_pop   = s1_adv && q_not_empty;

    assign span = $signed({max_reg[DATA_W-1], max_reg})
                - $signed({min_reg[DATA_W-1], min_reg});
    assign prod = span * $signed({1'b0, q_head.rnd});

    always_comb
    begin
        hold_next = hold_reg;
        if (s1_trig_reg)
            hold_next = min_reg + s1_off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN: min_reg <= cfg_data;
                CFG_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= q_not_empty;
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                    hold_reg <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_trig_reg <= q_head.trig;
            s1_off_reg  <= prod[2*DATA_W-1:DATA_W];
        end
        if (out_adv && s1_valid_reg)
            out_data_reg <= hold_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/triggered_random_sample_hold.sv @@
// ----------------------------------------------------------------------------
// triggered_random_sample_hold
// Sample-and-hold of xorshift128 random values, loaded when the input sample
// equals +1.0 (Q16.16), scaled into the configured [min, max) range.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[31:0] = trigger_sample
//  m_axis    out  m_axis_tvalid/tready    tdata[31:0] = held_value
//  cfg       in   cfg_we                  cfg_index (0 min, 1 max), cfg_data
//
//  One word per clock sustained while m_axis_tready is high; from accept to m_axis
//  a word passes the front/queue, the multiply stage and the output register.
//  Generator steps in the front on an accepted trigger; the 33x33 multiply sets the stage.
//  Reset loads the fixed seeds, range -1.0..+1.0 and a held value of zero.
//  A two-word queue lets the front accept while the back is stalled.
// ----------------------------------------------------------------------------
module triggered_random_sample_hold
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [trsh_pkg::DATA_W-1:0]       s_axis_tdata,   // [31:0] trigger_sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [trsh_pkg::DATA_W-1:0]       m_axis_tdata,   // [31:0] held_value
    input  logic                              cfg_we,
    input  logic [trsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trsh_pkg::DATA_W-1:0]       cfg_data
);
    import trsh_pkg::*;

    trsh_push_t q_push;
    trsh_word_t q_head;
    logic       q_full, q_not_empty, q_pop;

    trsh_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .q_full   (q_full),
        .in_ready (s_axis_tready),
        .q_push   (q_push)
    );

    trsh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    trsh_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .out_ready   (m_axis_tready)
    );

endmodule
